>>> design/lwr_pkg.sv
// ----------------------------------------------------------------------------
// lwr_pkg: shared types and constants for the loudest wavecycle replacer
// Register indexes, status codes, field widths and the store control bundle.
// ----------------------------------------------------------------------------
package lwr_pkg;

    // default sizing of the ping-pong sample store and of the samples
    localparam int BANK_DEPTH_DEF  = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed widths of the energy sum and of the cycle counters
    localparam int ENERGY_BITS = 28;
    localparam int COUNT_BITS  = 7;

    localparam logic [COUNT_BITS-1:0] COUNT_MIN   = 7'd1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 7'd64;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 7'd2;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_PHASE_ORDER = 1'b0,
        CFG_CYCLE_COUNT = 1'b1
    } t_cfg_reg;

    // status reported with a group close
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_ABANDONED = 2'd2
    } t_status;

    // control bundle from the sequencer to the sample store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_store_ctl;

endpackage

>>> design/lwr_store.sv
// ----------------------------------------------------------------------------
// lwr_store: ping-pong sample store
// Single write port and one registered read port over both banks.
// ----------------------------------------------------------------------------
module lwr_store
    import lwr_pkg::*;
#(
    parameter int DEPTH = 2 * BANK_DEPTH_DEF,
    parameter int WIDTH = SAMPLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  t_store_ctl               i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/loudest_wavecycle_replace.sv
// ----------------------------------------------------------------------------
// loudest_wavecycle_replace: loudest wavecycle replacer
// Splits audio into wavecycles, picks the loudest per group and replays it.
// ----------------------------------------------------------------------------
// For each accepted item, sample or pull, the cycle tracking, energy sum
// and loudest-cycle choice are settled in the cycle of the transfer and
// the result is registered, with a pull reading the play bank of the sample
// store through its registered read port at the same edge.
// A new item is taken every cycle as long as the result register is empty
// or its result is taken in that cycle. The store holds 2 x BANK_DEPTH
// entries as two banks: samples are recorded into one bank of BANK_DEPTH
// entries while the other bank plays; samples beyond a full bank are
// dropped and the group reports an overflow when it closes.
// The store holds no reset state: only entries written by the playing group
// are ever read, so no clearing pass is needed after reset.
module loudest_wavecycle_replace
    import lwr_pkg::*;
#(
    parameter int BANK_DEPTH  = BANK_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    // result channel
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    output logic                          o_out_valid,
    output logic                          o_group_closed,
    output logic [1:0]                    o_status,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [0:0]                    i_cfg_index,
    input  logic [COUNT_BITS-1:0]         i_cfg_data
);

    localparam int AW    = $clog2(BANK_DEPTH + 1);   // fill count 0..BANK_DEPTH
    localparam int OW    = $clog2(BANK_DEPTH);       // offset inside a bank
    localparam int MW    = $clog2(2 * BANK_DEPTH);   // store address
    localparam int SUM_W = ((ENERGY_BITS > SAMPLE_BITS) ? ENERGY_BITS : SAMPLE_BITS) + 1;
    localparam logic [ENERGY_BITS-1:0] ENERGY_SAT = {ENERGY_BITS{1'b1}};

    // configuration
    logic                  r_phase_order;
    logic [COUNT_BITS-1:0] r_cycle_count;

    // recording and choice state
    logic [AW-1:0]          r_write_addr, n_write_addr;
    logic                   r_record_bank, n_record_bank;
    logic                   r_second_half, n_second_half;
    logic [COUNT_BITS-1:0]  r_cycles_in_group, n_cycles_in_group;
    logic [AW-1:0]          r_cycle_start, n_cycle_start;
    logic [ENERGY_BITS-1:0] r_cycle_energy, n_cycle_energy;
    logic [ENERGY_BITS-1:0] r_best_energy, n_best_energy;
    logic [AW-1:0]          r_best_start, n_best_start;
    logic [AW-1:0]          r_best_length, n_best_length;
    logic                   r_overflow, n_overflow;

    // replay state
    logic [AW-1:0]         r_play_start, n_play_start;
    logic [AW-1:0]         r_play_length, n_play_length;
    logic [AW-1:0]         r_replay_addr, n_replay_addr;
    logic [COUNT_BITS-1:0] r_repeats_left, n_repeats_left;

    // result register
    logic    r_res_valid;
    logic    r_out_valid, n_out_valid;
    logic    r_closed, n_closed;
    t_status r_status, n_status;

    logic                   in_xfer;
    logic                   cfg_xfer;
    logic [COUNT_BITS-1:0]  eff_count;
    logic                   s_neg;
    logic                   s_zero;
    logic                   rule_ok;
    logic [SAMPLE_BITS-1:0] s_mag;
    logic [AW-1:0]          cyc_len;
    logic                   cyc_wins;
    logic [COUNT_BITS-1:0]  cig_inc;
    logic [SUM_W-1:0]       energy_sum;
    logic [AW:0]            rd_offset;
    t_store_ctl             store_ctl;
    logic [MW-1:0]          wr_addr;
    logic [MW-1:0]          rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;

    // handshakes
    assign in_xfer     = i_valid && o_ready;
    assign o_ready     = !r_res_valid || i_res_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    // effective group size, clamped to 1..64
    always_comb begin
        priority if (r_cycle_count == '0) begin
            eff_count = COUNT_MIN;
        end else if (r_cycle_count > COUNT_MAX) begin
            eff_count = COUNT_MAX;
        end else begin
            eff_count = r_cycle_count;
        end
    end

    // sign and magnitude of the incoming sample
    assign s_neg  = i_sample_value[SAMPLE_BITS-1];
    assign s_zero = (i_sample_value == '0);
    assign s_mag  = s_neg ? SAMPLE_BITS'(-i_sample_value) : SAMPLE_BITS'(i_sample_value);

    // sign rule of the current half: first half keeps the leading polarity
    assign rule_ok = (r_second_half ^ r_phase_order) ? (s_neg || s_zero) : !s_neg;

    // cycle end bookkeeping
    assign cyc_len  = r_write_addr - r_cycle_start;
    assign cyc_wins = !r_overflow &&
                      ((r_best_length == '0) || (r_cycle_energy > r_best_energy));
    assign cig_inc  = r_cycles_in_group + COUNT_BITS'(1);

    // next state for one accepted item
    always_comb begin
        n_write_addr      = r_write_addr;
        n_record_bank     = r_record_bank;
        n_second_half     = r_second_half;
        n_cycles_in_group = r_cycles_in_group;
        n_cycle_start     = r_cycle_start;
        n_cycle_energy    = r_cycle_energy;
        n_best_energy     = r_best_energy;
        n_best_start      = r_best_start;
        n_best_length     = r_best_length;
        n_overflow        = r_overflow;
        n_play_start      = r_play_start;
        n_play_length     = r_play_length;
        n_replay_addr     = r_replay_addr;
        n_repeats_left    = r_repeats_left;
        n_out_valid       = 1'b0;
        n_closed          = 1'b0;
        n_status          = ST_OK;
        energy_sum        = '0;
        store_ctl         = '0;

        if (i_kind) begin
            // pull: step through the playing cycle
            if (r_repeats_left != '0 && r_play_length != '0) begin
                n_out_valid     = 1'b1;
                store_ctl.rd_en = in_xfer;
                n_replay_addr   = r_replay_addr + AW'(1);
                if (n_replay_addr >= r_play_length) begin
                    n_replay_addr  = '0;
                    n_repeats_left = r_repeats_left - COUNT_BITS'(1);
                end
            end
        end else begin
            // sample: track the halves of the cycle
            if (!r_second_half) begin
                if (!rule_ok) begin
                    n_second_half = 1'b1;
                end
            end else if (!rule_ok) begin
                n_second_half = 1'b0;
                if (cyc_wins) begin
                    n_best_energy = r_cycle_energy;
                    n_best_start  = r_cycle_start;
                    n_best_length = cyc_len;
                end
                n_cycles_in_group = cig_inc;
                if (cig_inc >= eff_count) begin
                    // group close: latch the loudest cycle and swap banks
                    n_closed = 1'b1;
                    priority if (r_overflow) begin
                        n_status = ST_OVERFLOW;
                    end else if (r_repeats_left != '0) begin
                        n_status = ST_ABANDONED;
                    end else begin
                        n_status = ST_OK;
                    end
                    n_play_start      = n_best_start;
                    n_play_length     = n_best_length;
                    n_replay_addr     = '0;
                    n_repeats_left    = (n_best_length != '0) ? eff_count : '0;
                    n_record_bank     = !r_record_bank;
                    n_write_addr      = '0;
                    n_overflow        = 1'b0;
                    n_cycles_in_group = '0;
                    n_best_energy     = '0;
                    n_best_start      = '0;
                    n_best_length     = '0;
                end
                n_cycle_start  = n_write_addr;
                n_cycle_energy = '0;
            end

            // record the sample or drop it when the bank is full
            if (n_write_addr < AW'(BANK_DEPTH)) begin
                store_ctl.wr_en = in_xfer;
                n_write_addr    = n_write_addr + AW'(1);
            end else begin
                n_overflow = 1'b1;
            end

            // saturating energy sum
            energy_sum = SUM_W'(n_cycle_energy) + SUM_W'(s_mag);
            n_cycle_energy = (energy_sum > SUM_W'(ENERGY_SAT)) ? ENERGY_SAT
                                                              : ENERGY_BITS'(energy_sum);
        end
    end

    // store addresses: record bank for writes, the other bank for replay
    always_comb begin
        wr_addr = MW'(r_write_addr);
        if (r_second_half && !rule_ok && (cig_inc >= eff_count)) begin
            // closing sample goes to the start of the freshly swapped bank
            wr_addr = r_record_bank ? '0 : MW'(BANK_DEPTH);
        end else if (r_record_bank) begin
            wr_addr = MW'(r_write_addr) + MW'(BANK_DEPTH);
        end
    end

    assign rd_offset = {1'b0, r_play_start} + {1'b0, r_replay_addr};
    assign rd_addr   = r_record_bank ? MW'(rd_offset[OW-1:0])
                                     : MW'(rd_offset[OW-1:0]) + MW'(BANK_DEPTH);

    lwr_store #(
        .DEPTH (2 * BANK_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (store_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_sample_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_order <= 1'b0;
            r_cycle_count <= COUNT_RESET;
        end else if (cfg_xfer) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_PHASE_ORDER: r_phase_order <= i_cfg_data[0];
                CFG_CYCLE_COUNT: r_cycle_count <= i_cfg_data;
                default:         r_phase_order <= r_phase_order;
            endcase
        end
    end

    // block state, updated on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_addr      <= '0;
            r_record_bank     <= 1'b0;
            r_second_half     <= 1'b0;
            r_cycles_in_group <= '0;
            r_cycle_start     <= '0;
            r_cycle_energy    <= '0;
            r_best_energy     <= '0;
            r_best_start      <= '0;
            r_best_length     <= '0;
            r_overflow        <= 1'b0;
            r_play_start      <= '0;
            r_play_length     <= '0;
            r_replay_addr     <= '0;
            r_repeats_left    <= '0;
        end else if (in_xfer) begin
            r_write_addr      <= n_write_addr;
            r_record_bank     <= n_record_bank;
            r_second_half     <= n_second_half;
            r_cycles_in_group <= n_cycles_in_group;
            r_cycle_start     <= n_cycle_start;
            r_cycle_energy    <= n_cycle_energy;
            r_best_energy     <= n_best_energy;
            r_best_start      <= n_best_start;
            r_best_length     <= n_best_length;
            r_overflow        <= n_overflow;
            r_play_start      <= n_play_start;
            r_play_length     <= n_play_length;
            r_replay_addr     <= n_replay_addr;
            r_repeats_left    <= n_repeats_left;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_closed    <= 1'b0;
            r_status    <= ST_OK;
        end else if (in_xfer) begin
            r_res_valid <= 1'b1;
            r_out_valid <= n_out_valid;
            r_closed    <= n_closed;
            r_status    <= n_status;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_out_valid    = r_out_valid;
    assign o_out_sample   = r_out_valid ? rd_data : '0;
    assign o_group_closed = r_closed;
    assign o_status       = r_status;

    // fill count never passes the bank size, nor the cycle start the fill count
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_addr <= AW'(BANK_DEPTH) && r_cycle_start <= r_write_addr)
        else $error("fill count or cycle start out of range");

    // an active replay always has a cycle to play and at most COUNT_MAX repeats
    a_replay_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_repeats_left != '0 |-> r_play_length != '0 && r_repeats_left <= COUNT_MAX)
        else $error("replay active without a cycle");

    // a non-ok status only comes with a group close
    a_status_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_status != ST_OK |-> r_closed)
        else $error("status without group close");

    // a replayed sample never reports a group close
    a_pull_no_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !r_closed && r_status == ST_OK)
        else $error("pull result carries close flags");

    // a group close swaps the banks and restarts the fill
    a_close_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && n_closed |=> r_record_bank != $past(r_record_bank) && r_write_addr <= AW'(1))
        else $error("group close did not swap banks");

endmodule
